@@ hdl/akf_pkg.sv @@
package akf_pkg;

    localparam int FRAC_BITS = 20;
    localparam int DATA_W = 32;
    localparam int CFG_W = 31;
    localparam int ADDR_W = 2;

    localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] ONE_FX = DATA_W'(64'sd1 <<< FRAC_BITS);

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST =
        CFG_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST =
        CFG_W'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = CFG_W'((64'd1 << FRAC_BITS) / 64'd2);
    localparam logic [CFG_W-1:0] TIME_STEP_RST =
        CFG_W'(((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000);

    localparam logic [ADDR_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [ADDR_W-1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MEASURE_NOISE = 2'd2;
    localparam logic [ADDR_W-1:0] REG_TIME_STEP = 2'd3;

    // divider: 64-bit dividend magnitude, one quotient bit per cycle
    localparam int DIV_STEPS = 64;
    localparam int DIV_CNT_W = 7;

    typedef struct packed {
        logic start;
        logic signed [DATA_W-1:0] num;
        logic signed [DATA_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic signed [DATA_W-1:0] quot;
    } div_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat(input logic signed [DATA_W+1:0] v);
        if (v > (DATA_W+2)'(MAX_VAL)) begin
            return MAX_VAL;
        end else if (v < (DATA_W+2)'(MIN_VAL)) begin
            return MIN_VAL;
        end
        return v[DATA_W-1:0];
    endfunction

endpackage

@@ hdl/akf_div.sv @@
// Signed fixed-point divide: sat((num << FRAC_BITS) / den), truncated toward zero.
// Restoring, one quotient bit per cycle; a zero divisor returns a zero quotient.
module akf_div (
    input  logic                akf_clk,
    input  logic                akf_rstn,
    input  akf_pkg::div_req_t   req,
    output akf_pkg::div_rsp_t   rsp
);
    localparam int W = akf_pkg::DATA_W;

    logic [63:0]                     dvd_reg, dvd_next;
    logic [W:0]                      rem_reg, rem_next;
    logic [W-1:0]                    dsr_reg, dsr_next;
    logic                            neg_reg, neg_next;
    logic [akf_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic signed [W-1:0]             quot_reg, quot_next;

    logic [63:0]     num_mag;
    logic [W+1:0]    trial;
    logic [W:0]      shifted;
    logic [64:0]     q_signed;

    always_comb begin
        logic signed [63:0] num_ext;
        num_ext = 64'(signed'(req.num)) <<< akf_pkg::FRAC_BITS;
        num_mag = num_ext[63] ? 64'(-num_ext) : 64'(num_ext);
        shifted = {rem_reg[W-1:0], dvd_reg[63]};
        trial = {1'b0, shifted} - {2'b00, dsr_reg};
        q_signed = neg_reg ? 65'(-{1'b0, dvd_reg}) : {1'b0, dvd_reg};
    end

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quot_next = quot_reg;
        if (req.start) begin
            dvd_next = num_mag;
            rem_next = '0;
            dsr_next = req.den[W-1] ? W'(-req.den) : req.den;
            neg_next = req.num[W-1] ^ req.den[W-1];
            cnt_next = '0;
            busy_next = (req.den != '0);
            done_next = (req.den == '0);
            quot_next = '0;
        end else if (busy_reg) begin
            if (!trial[W+1]) begin
                rem_next = trial[W:0];
                dvd_next = {dvd_reg[62:0], 1'b1};
            end else begin
                rem_next = shifted;
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == akf_pkg::DIV_CNT_W'(akf_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end else if (cnt_reg == akf_pkg::DIV_CNT_W'(akf_pkg::DIV_STEPS)) begin
            // final sign and saturate
            if ($signed(q_signed) > 65'sd2147483647) begin
                quot_next = akf_pkg::MAX_VAL;
            end else if ($signed(q_signed) < -65'sd2147483648) begin
                quot_next = akf_pkg::MIN_VAL;
            end else begin
                quot_next = q_signed[W-1:0];
            end
            done_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge akf_clk) begin
        if (!akf_rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        quot_reg <= quot_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge akf_clk) disable iff (!akf_rstn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_one: assert property (@(posedge akf_clk) disable iff (!akf_rstn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_cnt_range: assert property (@(posedge akf_clk) disable iff (!akf_rstn)
        cnt_reg <= akf_pkg::DIV_CNT_W'(akf_pkg::DIV_STEPS))
        else $error("divider step count out of range");
`endif
endmodule

@@ hdl/akf_mac.sv @@
// Shared fixed-point unit: sat(acc + sgn * round(a*b >> F)), one registered result.
module akf_mac (
    input  logic                               akf_clk,
    input  logic signed [akf_pkg::DATA_W-1:0]  op_a,
    input  logic signed [akf_pkg::DATA_W-1:0]  op_b,
    input  logic signed [akf_pkg::DATA_W-1:0]  op_acc,
    input  logic                               op_sub,
    output logic signed [akf_pkg::DATA_W-1:0]  res
);
    localparam int W = akf_pkg::DATA_W;

    logic signed [W-1:0]   res_reg, res_next;
    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] rnd;
    logic signed [2*W-1:0] shf;
    logic signed [W-1:0]   pm;
    logic signed [W+1:0]   sum;

    always_comb begin
        prod = op_a * op_b;
        rnd = prod + (64'sd1 <<< (akf_pkg::FRAC_BITS - 1));
        shf = rnd >>> akf_pkg::FRAC_BITS;
        if (shf > 64'sd2147483647) begin
            pm = akf_pkg::MAX_VAL;
        end else if (shf < -64'sd2147483648) begin
            pm = akf_pkg::MIN_VAL;
        end else begin
            pm = shf[W-1:0];
        end
        sum = op_sub ? (W+2)'(op_acc) - (W+2)'(pm) : (W+2)'(op_acc) + (W+2)'(pm);
        res_next = akf_pkg::sat(sum);
    end

    always_ff @(posedge akf_clk) begin
        res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

@@ hdl/angle_kalman_filter.sv @@
// Two-state angle/gyro-bias Kalman filter, signed Q12.20 throughout with saturation.
// Each transaction on s_ runs a sequencer that issues eleven multiply-accumulate
// steps through one shared multiplier (one per cycle, result registered), and one
// 64-step restoring divide per gain; both gains use that divider in turn. s_ready is
// low from acceptance of a sample until the result on m_ is taken. Configuration
// writes are accepted any time; write them only while the block is idle. Every value
// of the 2-bit index selects one of the four configuration registers.
module angle_kalman_filter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [akf_pkg::DATA_W-1:0]   s_accel_angle,
    input  logic signed [akf_pkg::DATA_W-1:0]   s_gyro_rate,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [akf_pkg::DATA_W-1:0]   m_angle_est,
    output logic signed [akf_pkg::DATA_W-1:0]   m_rate_est,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [akf_pkg::ADDR_W-1:0]          cfg_index,
    input  logic [akf_pkg::CFG_W-1:0]           cfg_data
);
    localparam int W = akf_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ANG, S_AA, S_AB, S_BA, S_BB, S_ERR, S_DIV0, S_WAIT0, S_DIV1, S_WAIT1,
        S_UAA, S_UAB, S_UBA, S_UBB, S_UANG, S_UBIAS, S_OUT, S_HOLD
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [akf_pkg::CFG_W-1:0] q_ang_reg, q_bias_reg, r_meas_reg, dt_reg;

    // filter state
    logic signed [W-1:0] angle_reg, angle_next;
    logic signed [W-1:0] bias_reg, bias_next;
    logic signed [W-1:0] paa_reg, paa_next, pab_reg, pab_next;
    logic signed [W-1:0] pba_reg, pba_next, pbb_reg, pbb_next;

    // per-sample working registers
    logic signed [W-1:0] accel_reg, accel_next, gyro_reg, gyro_next;
    logic signed [W-1:0] err_reg, err_next, k0_reg, k0_next, k1_reg, k1_next;
    logic signed [W-1:0] t0_reg, t0_next, t1_reg, t1_next;
    logic signed [W-1:0] aout_reg, aout_next, rout_reg, rout_next;

    // shared multiply-accumulate unit
    logic signed [W-1:0] mac_a, mac_b, mac_acc, mac_res;
    logic                mac_sub;

    akf_pkg::div_req_t   div_req;
    akf_pkg::div_rsp_t   div_rsp;

    akf_mac u_mac (
        .akf_clk (aclk),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .op_acc  (mac_acc),
        .op_sub  (mac_sub),
        .res     (mac_res)
    );

    akf_div u_div (
        .akf_clk  (aclk),
        .akf_rstn (aresetn),
        .req      (div_req),
        .rsp      (div_rsp)
    );

    assign cfg_ready = 1'b1;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_HOLD);
    assign m_angle_est = aout_reg;
    assign m_rate_est = rout_reg;

    logic signed [W-1:0] dt_s;
    logic signed [W-1:0] d0;
    logic signed [W-1:0] neg_bb;
    assign dt_s = W'(dt_reg);
    assign d0 = akf_pkg::sat((W+2)'(signed'({1'b0, q_ang_reg})) - (W+2)'(pab_reg)
                             - (W+2)'(pba_reg));
    assign neg_bb = akf_pkg::sat(-(W+2)'(pbb_reg));

    always_comb begin
        state_next = state_reg;
        angle_next = angle_reg;  bias_next = bias_reg;
        paa_next = paa_reg;  pab_next = pab_reg;  pba_next = pba_reg;  pbb_next = pbb_reg;
        accel_next = accel_reg;  gyro_next = gyro_reg;
        err_next = err_reg;  k0_next = k0_reg;  k1_next = k1_reg;
        t0_next = t0_reg;  t1_next = t1_reg;
        aout_next = aout_reg;  rout_next = rout_reg;
        mac_a = dt_s;  mac_b = dt_s;  mac_acc = '0;  mac_sub = 1'b0;
        div_req = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    accel_next = s_accel_angle;
                    gyro_next = s_gyro_rate;
                    state_next = S_ANG;
                end
            end
            // predict: issue one product per cycle; each result lands in the next cycle
            S_ANG: begin
                mac_a = akf_pkg::sat((W+2)'(gyro_reg) - (W+2)'(bias_reg));
                mac_acc = angle_reg;
                state_next = S_AA;
            end
            S_AA: begin
                angle_next = mac_res;
                mac_a = d0;  mac_acc = paa_reg;
                state_next = S_AB;
            end
            S_AB: begin
                paa_next = mac_res;
                mac_a = neg_bb;  mac_acc = pab_reg;
                state_next = S_BA;
            end
            S_BA: begin
                pab_next = mac_res;
                mac_a = neg_bb;  mac_acc = pba_reg;
                state_next = S_BB;
            end
            S_BB: begin
                pba_next = mac_res;
                mac_a = signed'({1'b0, q_bias_reg});  mac_acc = pbb_reg;
                state_next = S_ERR;
            end
            S_ERR: begin
                pbb_next = mac_res;
                err_next = akf_pkg::sat((W+2)'(accel_reg) - (W+2)'(angle_reg));
                t0_next = paa_reg;
                t1_next = pab_reg;
                state_next = S_DIV0;
            end
            S_DIV0: begin
                div_req.start = 1'b1;
                div_req.num = paa_reg;
                div_req.den = akf_pkg::sat((W+2)'(signed'({1'b0, r_meas_reg}))
                                           + (W+2)'(paa_reg));
                state_next = S_WAIT0;
            end
            S_WAIT0: begin
                if (div_rsp.done) begin
                    k0_next = div_rsp.quot;
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                div_req.start = 1'b1;
                div_req.num = pba_reg;
                div_req.den = akf_pkg::sat((W+2)'(signed'({1'b0, r_meas_reg}))
                                           + (W+2)'(paa_reg));
                state_next = S_WAIT1;
            end
            S_WAIT1: begin
                if (div_rsp.done) begin
                    k1_next = div_rsp.quot;
                    state_next = S_UAA;
                end
            end
            // update: covariance uses the predicted t0/t1 copies
            S_UAA: begin
                mac_a = k0_reg;  mac_b = t0_reg;  mac_acc = paa_reg;  mac_sub = 1'b1;
                state_next = S_UAB;
            end
            S_UAB: begin
                paa_next = mac_res;
                mac_a = k0_reg;  mac_b = t1_reg;  mac_acc = pab_reg;  mac_sub = 1'b1;
                state_next = S_UBA;
            end
            S_UBA: begin
                pab_next = mac_res;
                mac_a = k1_reg;  mac_b = t0_reg;  mac_acc = pba_reg;  mac_sub = 1'b1;
                state_next = S_UBB;
            end
            S_UBB: begin
                pba_next = mac_res;
                mac_a = k1_reg;  mac_b = t1_reg;  mac_acc = pbb_reg;  mac_sub = 1'b1;
                state_next = S_UANG;
            end
            S_UANG: begin
                pbb_next = mac_res;
                mac_a = k0_reg;  mac_b = err_reg;  mac_acc = angle_reg;
                state_next = S_UBIAS;
            end
            S_UBIAS: begin
                angle_next = mac_res;
                mac_a = k1_reg;  mac_b = err_reg;  mac_acc = bias_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                bias_next = mac_res;
                aout_next = angle_reg;
                rout_next = akf_pkg::sat((W+2)'(gyro_reg) - (W+2)'(mac_res));
                state_next = S_HOLD;
            end
            S_HOLD: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            q_ang_reg <= akf_pkg::ANGLE_NOISE_RST;
            q_bias_reg <= akf_pkg::BIAS_NOISE_RST;
            r_meas_reg <= akf_pkg::MEASURE_NOISE_RST;
            dt_reg <= akf_pkg::TIME_STEP_RST;
            angle_reg <= '0;
            bias_reg <= '0;
            paa_reg <= akf_pkg::ONE_FX;
            pab_reg <= '0;
            pba_reg <= '0;
            pbb_reg <= akf_pkg::ONE_FX;
        end else begin
            state_reg <= state_next;
            angle_reg <= angle_next;
            bias_reg <= bias_next;
            paa_reg <= paa_next;
            pab_reg <= pab_next;
            pba_reg <= pba_next;
            pbb_reg <= pbb_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    akf_pkg::REG_ANGLE_NOISE:   q_ang_reg <= cfg_data;
                    akf_pkg::REG_BIAS_NOISE:    q_bias_reg <= cfg_data;
                    akf_pkg::REG_MEASURE_NOISE: r_meas_reg <= cfg_data;
                    akf_pkg::REG_TIME_STEP:     dt_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        accel_reg <= accel_next;
        gyro_reg <= gyro_next;
        err_reg <= err_next;
        k0_reg <= k0_next;
        k1_reg <= k1_next;
        t0_reg <= t0_next;
        t1_reg <= t1_next;
        aout_reg <= aout_next;
        rout_reg <= rout_next;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input accepted while a sample is in flight");
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_angle_est) && $stable(m_rate_est)))
        else $error("result dropped or changed while stalled");
    a_div_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HOLD || state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy outside the gain step");
`endif
endmodule
